/* hdl/nhpc_pkg.sv */
// Package for the name hash palette colour block: types, codes and constants.
// Used by every module under hdl; it depends on nothing.
package nhpc_pkg;

  // FNV-1a hash constants.
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  // Colour constants.
  localparam logic [7:0]  AlphaOpaque = 8'hFF;
  localparam logic [8:0]  HueWrap     = 9'd360;
  localparam logic [9:0]  HueWrap2    = 10'd720;
  localparam logic [6:0]  PctMax      = 7'd100;
  localparam logic [12:0] LitScale    = 13'd6000;

  // Rounded-up reciprocal of 625 scaled by 2^28; exact for dividends below 2^18.
  localparam logic [18:0] ChanRecip = 19'd429497;
  localparam int unsigned ChanShift = 28;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegHueBase = 3'd0;
  localparam logic [2:0] RegHueSpan = 3'd1;
  localparam logic [2:0] RegSatBase = 3'd2;
  localparam logic [2:0] RegSatSpan = 3'd3;
  localparam logic [2:0] RegLitBase = 3'd4;
  localparam logic [2:0] RegLitSpan = 3'd5;

  // Reset values of the registers.
  localparam logic [8:0] HueBaseRst = 9'd10;
  localparam logic [8:0] HueSpanRst = 9'd50;
  localparam logic [6:0] SatBaseRst = 7'd70;
  localparam logic [6:0] SatSpanRst = 7'd20;
  localparam logic [6:0] LitBaseRst = 7'd50;
  localparam logic [6:0] LitSpanRst = 7'd15;

  // Number of bit-serial remainder steps (one per hash bit).
  localparam int unsigned RemSteps = 32;

  typedef struct packed {
    logic [8:0] hue_base;
    logic [8:0] hue_span;
    logic [6:0] sat_base;
    logic [6:0] sat_span;
    logic [6:0] lit_base;
    logic [6:0] lit_span;
  } cfg_t;

  typedef enum logic [2:0] {
    StIdle,
    StRem,
    StHsl,
    StMul1,
    StMul2,
    StChan,
    StQuot,
    StDone
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       hash_en;
    logic       rem_step;
    logic       hsl_en;
    logic       mul1_en;
    logic       mul2_en;
    logic       chan_en;
    logic       quot_step;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

/* hdl/nhpc_cfg.sv */
// Configuration registers of the name hash palette colour block.
// Depends on nhpc_pkg for the register indexes, reset values and cfg_t.
module nhpc_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_index_i,
  input  logic [8:0]      cfg_data_i,
  output nhpc_pkg::cfg_t  cfg_o
);

  nhpc_pkg::cfg_t cfg_q, cfg_d;

  // Decode a write; indexes beyond the last register are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        nhpc_pkg::RegHueBase: cfg_d.hue_base = cfg_data_i;
        nhpc_pkg::RegHueSpan: cfg_d.hue_span = cfg_data_i;
        nhpc_pkg::RegSatBase: cfg_d.sat_base = cfg_data_i[6:0];
        nhpc_pkg::RegSatSpan: cfg_d.sat_span = cfg_data_i[6:0];
        nhpc_pkg::RegLitBase: cfg_d.lit_base = cfg_data_i[6:0];
        nhpc_pkg::RegLitSpan: cfg_d.lit_span = cfg_data_i[6:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_base <= nhpc_pkg::HueBaseRst;
      cfg_q.hue_span <= nhpc_pkg::HueSpanRst;
      cfg_q.sat_base <= nhpc_pkg::SatBaseRst;
      cfg_q.sat_span <= nhpc_pkg::SatSpanRst;
      cfg_q.lit_base <= nhpc_pkg::LitBaseRst;
      cfg_q.lit_span <= nhpc_pkg::LitSpanRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/nhpc_ctrl.sv */
// Controller state machine of the name hash palette colour block.
// Depends on nhpc_pkg for state_e, cmd_t and sts_t; drives the datapath.
module nhpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           last_i,
  output logic           in_stall_o,
  input  nhpc_pkg::sts_t sts_i,
  output nhpc_pkg::cmd_t cmd_o
);

  nhpc_pkg::state_e state_q, state_d;
  logic [4:0]       cnt_q, cnt_d;

  // Next state and step counter.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      nhpc_pkg::StIdle: begin
        cnt_d = '0;
        if (in_valid_i && last_i) begin
          state_d = nhpc_pkg::StRem;
        end
      end
      nhpc_pkg::StRem: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(nhpc_pkg::RemSteps - 1)) begin
          state_d = nhpc_pkg::StHsl;
        end
      end
      nhpc_pkg::StHsl:  state_d = nhpc_pkg::StMul1;
      nhpc_pkg::StMul1: state_d = nhpc_pkg::StMul2;
      nhpc_pkg::StMul2: state_d = nhpc_pkg::StChan;
      nhpc_pkg::StChan: state_d = nhpc_pkg::StQuot;
      nhpc_pkg::StQuot: state_d = nhpc_pkg::StDone;
      nhpc_pkg::StDone: begin
        if (sts_i.out_free) begin
          state_d = nhpc_pkg::StIdle;
        end
      end
      default: state_d = nhpc_pkg::StIdle;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      nhpc_pkg::StIdle: begin
        in_stall_o    = 1'b0;
        cmd_o.hash_en = in_valid_i;
      end
      nhpc_pkg::StRem:  cmd_o.rem_step  = 1'b1;
      nhpc_pkg::StHsl:  cmd_o.hsl_en    = 1'b1;
      nhpc_pkg::StMul1: cmd_o.mul1_en   = 1'b1;
      nhpc_pkg::StMul2: cmd_o.mul2_en   = 1'b1;
      nhpc_pkg::StChan: cmd_o.chan_en   = 1'b1;
      nhpc_pkg::StQuot: cmd_o.quot_step = 1'b1;
      nhpc_pkg::StDone: cmd_o.out_load  = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nhpc_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* hdl/nhpc_dpath.sv */
// Datapath of the name hash palette colour block: hash, remainders, HSL to RGB.
// Depends on nhpc_pkg for constants, cfg_t, cmd_t and sts_t.
module nhpc_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nhpc_pkg::cfg_t cfg_i,
  input  nhpc_pkg::cmd_t cmd_i,
  output nhpc_pkg::sts_t sts_o,
  input  logic [7:0]     name_byte_i,
  input  logic           last_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    color_word_o,
  output logic [31:0]    name_hash_o
);

  // Running hash and the folded value for the current beat.
  logic [31:0] run_hash_q;
  logic [31:0] hash_next;
  logic [31:0] final_hash_q;

  assign hash_next = 32'((run_hash_q ^ {{24{name_byte_i[7]}}, name_byte_i})
                         * nhpc_pkg::FnvPrime);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_hash_q <= nhpc_pkg::FnvBasis;
    end else if (cmd_i.hash_en) begin
      run_hash_q <= last_i ? nhpc_pkg::FnvBasis : hash_next;
    end
  end

  // Bit-serial remainders of the three hash slices, one dividend bit a cycle.
  logic [31:0] hue_dvd_q, sat_dvd_q, lit_dvd_q;
  logic [8:0]  hue_rem_q;
  logic [6:0]  sat_rem_q, lit_rem_q;
  logic [9:0]  hue_try;
  logic [7:0]  sat_try, lit_try;
  logic [8:0]  hue_rem_d;
  logic [6:0]  sat_rem_d, lit_rem_d;

  always_comb begin
    hue_try   = {hue_rem_q, hue_dvd_q[31]};
    sat_try   = {sat_rem_q, sat_dvd_q[31]};
    lit_try   = {lit_rem_q, lit_dvd_q[31]};
    hue_rem_d = hue_try[8:0];
    sat_rem_d = sat_try[6:0];
    lit_rem_d = lit_try[6:0];
    if (hue_try >= {1'b0, cfg_i.hue_span}) begin
      hue_rem_d = 9'(hue_try - {1'b0, cfg_i.hue_span});
    end
    if (sat_try >= {1'b0, cfg_i.sat_span}) begin
      sat_rem_d = 7'(sat_try - {1'b0, cfg_i.sat_span});
    end
    if (lit_try >= {1'b0, cfg_i.lit_span}) begin
      lit_rem_d = 7'(lit_try - {1'b0, cfg_i.lit_span});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_en && last_i) begin
      final_hash_q <= hash_next;
      hue_dvd_q    <= hash_next;
      sat_dvd_q    <= {8'd0, hash_next[31:8]};
      lit_dvd_q    <= {16'd0, hash_next[31:16]};
      hue_rem_q    <= '0;
      sat_rem_q    <= '0;
      lit_rem_q    <= '0;
    end else if (cmd_i.rem_step) begin
      hue_dvd_q <= {hue_dvd_q[30:0], 1'b0};
      sat_dvd_q <= {sat_dvd_q[30:0], 1'b0};
      lit_dvd_q <= {lit_dvd_q[30:0], 1'b0};
      hue_rem_q <= hue_rem_d;
      sat_rem_q <= sat_rem_d;
      lit_rem_q <= lit_rem_d;
    end
  end

  // Hue, saturation and lightness; a zero span gives a zero offset.
  logic [9:0] hue_sum;
  logic [7:0] sat_sum, lit_sum;
  logic [8:0] hue_d, hue_q;
  logic [6:0] sat_d, sat_q, lit_d, lit_q;

  always_comb begin
    hue_sum = {1'b0, cfg_i.hue_base}
            + ((cfg_i.hue_span == '0) ? 10'd0 : {1'b0, hue_rem_q});
    sat_sum = {1'b0, cfg_i.sat_base}
            + ((cfg_i.sat_span == '0) ? 8'd0 : {1'b0, sat_rem_q});
    lit_sum = {1'b0, cfg_i.lit_base}
            + ((cfg_i.lit_span == '0) ? 8'd0 : {1'b0, lit_rem_q});
    if (hue_sum >= nhpc_pkg::HueWrap2) begin
      hue_d = 9'(hue_sum - nhpc_pkg::HueWrap2);
    end else if (hue_sum >= {1'b0, nhpc_pkg::HueWrap}) begin
      hue_d = 9'(hue_sum - {1'b0, nhpc_pkg::HueWrap});
    end else begin
      hue_d = hue_sum[8:0];
    end
    sat_d = (sat_sum > {1'b0, nhpc_pkg::PctMax}) ? nhpc_pkg::PctMax : sat_sum[6:0];
    lit_d = (lit_sum > {1'b0, nhpc_pkg::PctMax}) ? nhpc_pkg::PctMax : lit_sum[6:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hsl_en) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      lit_q <= lit_d;
    end
  end

  // Chroma in 1/10000, triangle weight and sextant of the hue.
  logic [7:0]  two_l;
  logic [6:0]  lum_dev;
  logic [8:0]  hue_mod;
  logic [5:0]  tri_d, tri_q;
  logic [2:0]  sext_d, sext_q;
  logic [13:0] c4_q;
  logic [6:0]  lit2_q;

  always_comb begin
    two_l = {lit_q, 1'b0};
    if (two_l >= {1'b0, nhpc_pkg::PctMax}) begin
      lum_dev = 7'(two_l - {1'b0, nhpc_pkg::PctMax});
    end else begin
      lum_dev = 7'({1'b0, nhpc_pkg::PctMax} - two_l);
    end
    if (hue_q >= 9'd240) begin
      hue_mod = hue_q - 9'd240;
    end else if (hue_q >= 9'd120) begin
      hue_mod = hue_q - 9'd120;
    end else begin
      hue_mod = hue_q;
    end
    tri_d = (hue_mod >= 9'd60) ? 6'(9'd120 - hue_mod) : hue_mod[5:0];
    if (hue_q < 9'd60) begin
      sext_d = 3'd0;
    end else if (hue_q < 9'd120) begin
      sext_d = 3'd1;
    end else if (hue_q < 9'd180) begin
      sext_d = 3'd2;
    end else if (hue_q < 9'd240) begin
      sext_d = 3'd3;
    end else if (hue_q < 9'd300) begin
      sext_d = 3'd4;
    end else begin
      sext_d = 3'd5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1_en) begin
      c4_q   <= 14'((nhpc_pkg::PctMax - lum_dev) * sat_q);
      tri_q  <= tri_d;
      sext_q <= sext_d;
      lit2_q <= lit_q;
    end
  end

  // Chroma, second component and offset, all in 1/600000.
  logic [19:0] cc_q, xx_q, m_q;
  logic [2:0]  sext2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2_en) begin
      cc_q    <= 20'(c4_q * 6'd60);
      xx_q    <= 20'(c4_q * tri_q);
      m_q     <= 20'(20'(lit2_q * nhpc_pkg::LitScale) - 20'(c4_q * 5'd30));
      sext2_q <= sext_q;
    end
  end

  // Sextant selection, then (v + m) * 17 / 64; 255 / 600000 is 17 / 40000 and
  // 40000 is 64 * 625, so only a divide by 625 remains.
  logic [19:0] r1, g1, b1;
  logic [23:0] vr, vg, vb;
  logic [17:0] pr_q, pg_q, pb_q;
  logic [17:0] pr_d, pg_d, pb_d;

  always_comb begin
    case (sext2_q)
      3'd0:    begin r1 = cc_q; g1 = xx_q; b1 = '0;   end
      3'd1:    begin r1 = xx_q; g1 = cc_q; b1 = '0;   end
      3'd2:    begin r1 = '0;   g1 = cc_q; b1 = xx_q; end
      3'd3:    begin r1 = '0;   g1 = xx_q; b1 = cc_q; end
      3'd4:    begin r1 = xx_q; g1 = '0;   b1 = cc_q; end
      default: begin r1 = cc_q; g1 = '0;   b1 = xx_q; end
    endcase
    vr   = 24'(r1 + m_q) * 24'd17;
    vg   = 24'(g1 + m_q) * 24'd17;
    vb   = 24'(b1 + m_q) * 24'd17;
    pr_d = vr[23:6];
    pg_d = vg[23:6];
    pb_d = vb[23:6];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.chan_en) begin
      pr_q <= pr_d;
      pg_q <= pg_d;
      pb_q <= pb_d;
    end
  end

  // Divide by 625 as a multiply by the scaled reciprocal; the quotient never exceeds 255.
  logic [36:0] prod_r, prod_g, prod_b;
  logic [7:0]  qr_q, qg_q, qb_q;

  assign prod_r = 37'(pr_q) * 37'(nhpc_pkg::ChanRecip);
  assign prod_g = 37'(pg_q) * 37'(nhpc_pkg::ChanRecip);
  assign prod_b = 37'(pb_q) * 37'(nhpc_pkg::ChanRecip);

  always_ff @(posedge clk_i) begin
    if (cmd_i.quot_step) begin
      qr_q <= prod_r[nhpc_pkg::ChanShift +: 8];
      qg_q <= prod_g[nhpc_pkg::ChanShift +: 8];
      qb_q <= prod_b[nhpc_pkg::ChanShift +: 8];
    end
  end

  // Output register; the next name streams in while a result waits here.
  logic        out_valid_q;
  logic [31:0] color_q, hash_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      color_q    <= {nhpc_pkg::AlphaOpaque, qb_q, qg_q, qr_q};
      hash_out_q <= final_hash_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign color_word_o   = color_q;
  assign name_hash_o    = hash_out_q;

endmodule

/* hdl/name_hash_palette_color_top.sv */
// Top level of the name hash palette colour block: FNV-1a name hash to RGBA.
// Depends on nhpc_pkg and instantiates nhpc_cfg, nhpc_ctrl and nhpc_dpath.
//
//   Channel  Direction  Handshake                Payload
//   input    in         in_valid_i / in_stall_o  name_byte_i, last_i
//   output   out        out_valid_o / out_stall_i color_word_o, name_hash_o
//   config   in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// A byte not marked last is taken at once, so a name streams in at one byte a cycle.
// After the last byte, in_stall_o stays high through the 32 steps of the
// bit-serial remainder unit, four arithmetic stages, the reciprocal divide and the load.
// The result waits in an output register, so the next name starts while it is held;
// the load waits only while a previous result is still unclaimed.
// Reset is asynchronous: registers take their defaults and the hash its basis.
module name_hash_palette_color_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  name_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] color_word_o,
  output logic [31:0] name_hash_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  nhpc_pkg::cfg_t cfg;
  nhpc_pkg::cmd_t cmd;
  nhpc_pkg::sts_t sts;

  nhpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  nhpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nhpc_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .name_byte_i  (name_byte_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .color_word_o (color_word_o),
    .name_hash_o  (name_hash_o)
  );

`ifndef SYNTHESIS
  // The last beat of a name starts the colour work, which blocks input.
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> in_stall_o)
    else $error("input not stalled after the last beat of a name");

  // A load never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("output register loaded while holding an unclaimed result");

  // A load always presents a result in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");
`endif

endmodule

/* tb/name_hash_palette_color_checker.sv */
// Checker for the name hash palette colour block: watches the byte, result and register ports.
// It folds each accepted byte into its own FNV-1a hash and predicts the colour of each name.
// Depends on nhpc_pkg for the register indexes and the register set type.
module name_hash_palette_color_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  name_byte_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] color_word_i,
  input  logic [31:0] name_hash_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned colours_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] OffsetBasis = 32'd2166136261;
  localparam logic [31:0] HashPrime   = 32'd16777619;
  localparam logic [7:0]  AlphaByte   = 8'hFF;

  // Register values after reset.
  localparam nhpc_pkg::cfg_t PaletteDefaults = '{
    hue_base: 9'd10, hue_span: 9'd50,
    sat_base: 7'd70, sat_span: 7'd20,
    lit_base: 7'd50, lit_span: 7'd15
  };

  typedef struct packed {
    logic [31:0] color_word;
    logic [31:0] name_hash;
  } palette_result_t;

  palette_result_t owed_colours[$];
  nhpc_pkg::cfg_t  palette_cfg;
  logic [31:0]     name_fold;

  // One FNV-1a step; the byte is widened as a signed char would be.
  function automatic logic [31:0] fnv_fold(logic [31:0] acc, logic [7:0] b);
    logic [31:0] widened;
    widened = {{24{b[7]}}, b};
    return (acc ^ widened) * HashPrime;
  endfunction

  // A channel held in units of 1/600000, scaled to 0..255 and truncated.
  function automatic logic [7:0] channel_byte(int unsigned v, int unsigned m);
    int unsigned scaled;
    scaled = ((v + m) * 255) / 600000;
    return scaled[7:0];
  endfunction

  // Hue, saturation and lightness picked from the hash, then the six-sextant rule.
  function automatic logic [31:0] palette_colour(logic [31:0] h32, nhpc_pkg::cfg_t cfg);
    int unsigned hue, sat, lit, lum_dev, chroma, hm, ramp, cc, xx, m, r1, g1, b1;
    hue = cfg.hue_base;
    if (cfg.hue_span != 0) hue = hue + h32 % cfg.hue_span;
    hue = hue % 360;
    sat = cfg.sat_base;
    if (cfg.sat_span != 0) sat = sat + (h32 >> 8) % cfg.sat_span;
    if (sat > 100) sat = 100;
    lit = cfg.lit_base;
    if (cfg.lit_span != 0) lit = lit + (h32 >> 16) % cfg.lit_span;
    if (lit > 100) lit = 100;
    lum_dev = (2 * lit >= 100) ? 2 * lit - 100 : 100 - 2 * lit;
    chroma  = (100 - lum_dev) * sat;
    hm      = hue % 120;
    ramp    = 60 - ((hm >= 60) ? hm - 60 : 60 - hm);
    cc      = chroma * 60;
    xx      = chroma * ramp;
    m       = lit * 6000 - chroma * 30;
    if (hue < 60) begin
      r1 = cc; g1 = xx; b1 = 0;
    end else if (hue < 120) begin
      r1 = xx; g1 = cc; b1 = 0;
    end else if (hue < 180) begin
      r1 = 0;  g1 = cc; b1 = xx;
    end else if (hue < 240) begin
      r1 = 0;  g1 = xx; b1 = cc;
    end else if (hue < 300) begin
      r1 = xx; g1 = 0;  b1 = cc;
    end else begin
      r1 = cc; g1 = 0;  b1 = xx;
    end
    return {AlphaByte, channel_byte(b1, m), channel_byte(g1, m), channel_byte(r1, m)};
  endfunction

  // Register writes, byte beats and result beats, all taken at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : score
    palette_result_t got;
    palette_result_t want;
    palette_result_t fresh;
    if (!rst_ni) begin
      name_fold        = OffsetBasis;
      palette_cfg      = PaletteDefaults;
      mismatch_count_o = 0;
      owed_colours.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          nhpc_pkg::RegHueBase: palette_cfg.hue_base = cfg_data_i;
          nhpc_pkg::RegHueSpan: palette_cfg.hue_span = cfg_data_i;
          nhpc_pkg::RegSatBase: palette_cfg.sat_base = cfg_data_i[6:0];
          nhpc_pkg::RegSatSpan: palette_cfg.sat_span = cfg_data_i[6:0];
          nhpc_pkg::RegLitBase: palette_cfg.lit_base = cfg_data_i[6:0];
          nhpc_pkg::RegLitSpan: palette_cfg.lit_span = cfg_data_i[6:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        name_fold = fnv_fold(name_fold, name_byte_i);
        if (last_i) begin
          fresh        = '{palette_colour(name_fold, palette_cfg), name_fold};
          owed_colours = {owed_colours, fresh};
          name_fold    = OffsetBasis;
        end
      end

      if (out_valid_i && !out_stall_i) begin
        got = '{color_word_i, name_hash_i};
        if (owed_colours.size() == 0) begin
          $display("%0t: result beat with nothing owed: colour %h hash %h",
                   $time, got.color_word, got.name_hash);
          mismatch_count_o++;
        end else begin
          want = owed_colours.pop_front();
          if (got.color_word !== want.color_word) begin
            $display("%0t: color_word expected %h actual %h (hash %h)",
                     $time, want.color_word, got.color_word, want.name_hash);
            mismatch_count_o++;
          end
          if (got.name_hash !== want.name_hash) begin
            $display("%0t: name_hash expected %h actual %h",
                     $time, want.name_hash, got.name_hash);
            mismatch_count_o++;
          end
        end
      end
    end
    colours_owed_o = owed_colours.size();
  end

endmodule

/* tb/tb_top.sv */
// Test top for the name hash palette colour block: clock, reset, name bytes, register writes.
// Instantiates name_hash_palette_color_top and name_hash_palette_color_checker;
// the checker does the scoring and this module gives the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned IdlePct      = 14;
  localparam int unsigned RandomBeats  = 1900;
  localparam int unsigned Phases       = 8;

  // Indexes past the register file; writes to them must change nothing.
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  name_byte;
  logic        name_last;
  logic        colour_valid;
  logic        colour_stall;
  logic [31:0] colour_word;
  logic [31:0] colour_hash;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_data;

  int unsigned mismatches;
  int unsigned colours_owed;
  int unsigned beats_sent;
  int unsigned cycle_count;
  bit          quiet;
  bit          hold_req;

  name_hash_palette_color_top u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (byte_valid),
    .in_stall_o   (byte_stall),
    .name_byte_i  (name_byte),
    .last_i       (name_last),
    .out_valid_o  (colour_valid),
    .out_stall_i  (colour_stall),
    .color_word_o (colour_word),
    .name_hash_o  (colour_hash),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  name_hash_palette_color_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (byte_valid),
    .in_stall_i       (byte_stall),
    .name_byte_i      (name_byte),
    .last_i           (name_last),
    .out_valid_i      (colour_valid),
    .out_stall_i      (colour_stall),
    .color_word_i     (colour_word),
    .name_hash_i      (colour_hash),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .colours_owed_o   (colours_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, no stalls while quiet, and one long hold-off on request.
  initial begin
    colour_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        colour_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      colour_stall <= !quiet && ($urandom_range(99) < IdlePct);
    end
  end

  // One byte beat, with random idle cycles ahead of it unless quiet; returns once the beat is taken.
  task automatic send_beat(input logic [7:0] b, input logic is_last);
    logic taken;
    if (!quiet) begin
      while ($urandom_range(99) < IdlePct) begin
        byte_valid <= 1'b0;
        @(posedge clk);
      end
    end
    byte_valid <= 1'b1;
    name_byte  <= b;
    name_last  <= is_last;
    do begin
      @(negedge clk);
      taken = !byte_stall;
      @(posedge clk);
    end while (!taken);
    beats_sent++;
  endtask

  // A whole name: mostly printable characters, some bytes from the full range.
  task automatic send_name(input int unsigned len);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 35) b = 8'($urandom_range(255));
      else b = 8'($urandom_range(126, 32));
      send_beat(b, i == len - 1);
    end
  endtask

  // Stop sending, let every owed colour arrive and let the block fall idle.
  task automatic settle();
    byte_valid <= 1'b0;
    @(negedge clk);
    wait (colours_owed == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_palette(input logic [8:0] hb, input logic [8:0] hs,
                              input logic [8:0] sb, input logic [8:0] ss,
                              input logic [8:0] lb, input logic [8:0] ls);
    write_reg(nhpc_pkg::RegHueBase, hb);
    write_reg(nhpc_pkg::RegHueSpan, hs);
    write_reg(nhpc_pkg::RegSatBase, sb);
    write_reg(nhpc_pkg::RegSatSpan, ss);
    write_reg(nhpc_pkg::RegLitBase, lb);
    write_reg(nhpc_pkg::RegLitSpan, ls);
    cfg_we <= 1'b0;
  endtask

  // A register value: usually in its legal range, sometimes any nine bits.
  function automatic logic [8:0] pick_reg(input int unsigned lo, input int unsigned hi);
    if ($urandom_range(99) < 20) return 9'($urandom_range(511));
    return 9'($urandom_range(hi, lo));
  endfunction

  initial begin
    int unsigned phase_start;
    int unsigned name_len;
    rst_n      <= 1'b0;
    byte_valid <= 1'b0;
    name_byte  <= 8'h00;
    name_last  <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= nhpc_pkg::RegHueBase;
    cfg_data   <= 9'd0;
    beats_sent  = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: single-byte names at the byte extremes and around the sign bit,
    // then names that mix both halves of the byte range.
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h80, 1'b1);
    send_beat(8'h7F, 1'b1);
    send_beat(8'h01, 1'b0);
    send_beat(8'h81, 1'b0);
    send_beat(8'hFE, 1'b1);
    send_beat(8'h55, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h33, 1'b0);
    send_beat(8'hCC, 1'b1);

    // Every register at the top of its range: lightness full, so white.
    settle();
    load_palette(9'd359, 9'd360, 9'd100, 9'd100, 9'd100, 9'd100);
    send_name(3);
    send_beat(8'h9C, 1'b1);

    // Every register at the bottom of its range: lightness zero, so black.
    settle();
    load_palette(9'd0, 9'd1, 9'd0, 9'd1, 9'd0, 9'd1);
    send_beat(8'h41, 1'b1);
    send_beat(8'hC1, 1'b1);

    // Full saturation at mid lightness over the whole hue circle.
    settle();
    load_palette(9'd0, 9'd360, 9'd100, 9'd1, 9'd50, 9'd1);
    send_beat(8'h10, 1'b1);
    send_beat(8'h20, 1'b1);
    send_beat(8'hF0, 1'b1);

    // Zero spans, hue base past 360, saturation base past 100 after masking,
    // lightness base with high bits that masking removes; then writes past the last index.
    settle();
    load_palette(9'h1FF, 9'd0, 9'h1FF, 9'd0, 9'h0B2, 9'd0);
    write_reg(RegSpareLo, 9'h1FF);
    write_reg(RegSpareHi, 9'h000);
    cfg_we <= 1'b0;
    send_beat(8'h62, 1'b1);
    send_beat(8'hE2, 1'b1);

    // Random settings per phase; one phase runs with no idling, one holds the results off.
    for (int unsigned p = 0; p < Phases; p++) begin
      settle();
      load_palette(pick_reg(0, 359), pick_reg(1, 360), pick_reg(0, 100),
                   pick_reg(1, 100), pick_reg(0, 100), pick_reg(1, 100));
      quiet = (p == 2);
      if (p == 4) hold_req = 1'b1;
      phase_start = beats_sent;
      while (beats_sent - phase_start < RandomBeats / Phases) begin
        if ($urandom_range(19) == 0) name_len = $urandom_range(64, 13);
        else name_len = $urandom_range(12, 1);
        send_name(name_len);
      end
    end
    quiet = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/nhpc_pkg.sv
hdl/nhpc_cfg.sv
hdl/nhpc_ctrl.sv
hdl/nhpc_dpath.sv
hdl/name_hash_palette_color_top.sv
tb/name_hash_palette_color_checker.sv
tb/tb_top.sv
